// ===== sv/ctp_pkg.sv =====
// Shared types and constants for the countdown timer pool.
package ctp_pkg;

    localparam int NUM_SLOTS_DEF  = 16;
    localparam int TIME_WIDTH_DEF = 32;

    localparam int SLOT_W     = 4;
    localparam int REM_W      = 32;
    localparam int FUNC_W     = 3;
    localparam int ID_W       = 5;
    localparam int IN_TIME_W  = 32;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 40;

    typedef enum logic [FUNC_W-1:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_TICK   = 3'd3,
        OP_QUERY  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_QWAIT,
        ST_DONE
    } state_t;

    // packed high to low so that slot_out lands in the lowest bits
    typedef struct packed {
        logic             full_res;
        logic [REM_W-1:0] remaining;
        logic             done_res;
        logic [SLOT_W-1:0] slot_out;
    } res_t;

endpackage

// ===== sv/countdown_timer_pool_core.sv =====
// Top level of the countdown timer pool: stream ports, slot RAMs, result register.
//
// One operation enters per s_* transfer; every operation yields exactly one
// m_* transfer. s_tuser carries the operation code, s_tdata its operands.
// Operations are handled one at a time. Insert into a valid slot, delete,
// delete-all and unknown codes finish straight from decode; a query of a
// valid slot waits for the registered read of the slot RAMs; tick and
// searching insert walk the used entries through the single read port of
// the slot RAMs, one entry per cycle, with the write-back of the previous
// entry overlapped, and an insert stops at the first inactive entry. A new
// input is taken once the result has moved into the output register, so
// one result may wait while the next operation runs.
// Active marks and remaining times sit in two RAMs; only entries below the
// used count are ever used, and each was written when it was appended.
// Reset (rst_n low, asynchronous) empties the bank and drops any held
// result. When m_tready is low the result holds in the output register and
// the sequencer waits with its own result until the register frees up.
module countdown_timer_pool_core #(
    parameter int NUM_SLOTS  = ctp_pkg::NUM_SLOTS_DEF,
    parameter int TIME_WIDTH = ctp_pkg::TIME_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // slot_id[4:0], duration[36:5], elapsed[68:37], zero pad[71:69]
    input  logic [ctp_pkg::S_TDATA_W-1:0]   s_tdata,
    // func[2:0]
    input  logic [ctp_pkg::FUNC_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // slot_out[3:0], done_res[4], remaining[36:5], full_res[37], zero pad[39:38]
    output logic [ctp_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int PAD_W = ctp_pkg::M_TDATA_W - $bits(ctp_pkg::res_t);

    logic                  act_we;
    logic                  act_wdata;
    logic                  act_rdata;
    logic                  time_we;
    logic [TIME_WIDTH-1:0] time_wdata;
    logic [TIME_WIDTH-1:0] time_rdata;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic                  res_valid;
    logic                  res_ready;
    ctp_pkg::res_t         res;

    logic                            m_tvalid_reg, m_tvalid_next;
    logic [ctp_pkg::M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    ctp_ctrl #(
        .NUM_SLOTS  (NUM_SLOTS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .func       (s_tuser),
        .slot_id    (s_tdata[4:0]),
        .duration   (s_tdata[36:5]),
        .elapsed    (s_tdata[68:37]),
        .act_we     (act_we),
        .act_wdata  (act_wdata),
        .time_we    (time_we),
        .time_wdata (time_wdata),
        .wr_addr    (wr_addr),
        .rd_addr    (rd_addr),
        .act_rdata  (act_rdata),
        .time_rdata (time_rdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // active marks
    ctp_ram #(
        .WIDTH (1),
        .DEPTH (NUM_SLOTS)
    ) u_act_ram (
        .clk   (clk),
        .we    (act_we),
        .waddr (wr_addr),
        .wdata (act_wdata),
        .raddr (rd_addr),
        .rdata (act_rdata)
    );

    // remaining times
    ctp_ram #(
        .WIDTH (TIME_WIDTH),
        .DEPTH (NUM_SLOTS)
    ) u_time_ram (
        .clk   (clk),
        .we    (time_we),
        .waddr (wr_addr),
        .wdata (time_wdata),
        .raddr (rd_addr),
        .rdata (time_rdata)
    );

    // output register: free when empty or being drained this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{PAD_W{1'b0}}, res};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sv/ctp_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module ctp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/ctp_ctrl.sv =====
// Operation sequencer: decode, slot scan, read-modify-write of the slot RAMs.
module ctp_ctrl #(
    parameter int NUM_SLOTS  = ctp_pkg::NUM_SLOTS_DEF,
    parameter int TIME_WIDTH = ctp_pkg::TIME_WIDTH_DEF,
    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ctp_pkg::FUNC_W-1:0]      func,
    input  logic signed [ctp_pkg::ID_W-1:0] slot_id,
    input  logic [ctp_pkg::IN_TIME_W-1:0]   duration,
    input  logic [ctp_pkg::IN_TIME_W-1:0]   elapsed,
    output logic                            act_we,
    output logic                            act_wdata,
    output logic                            time_we,
    output logic [TIME_WIDTH-1:0]           time_wdata,
    output logic [AW-1:0]                   wr_addr,
    output logic [AW-1:0]                   rd_addr,
    input  logic                            act_rdata,
    input  logic [TIME_WIDTH-1:0]           time_rdata,
    output logic                            res_valid,
    input  logic                            res_ready,
    output ctp_pkg::res_t                   res
);

    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int IW = (CW > 4) ? CW : 4;

    ctp_pkg::state_t        state_reg, state_next;
    ctp_pkg::op_t           func_reg, func_next;
    logic [TIME_WIDTH-1:0]  dur_reg, dur_next;
    logic [TIME_WIDTH-1:0]  el_reg, el_next;
    logic [CW-1:0]          used_reg, used_next;
    logic [CW-1:0]          rd_idx_reg, rd_idx_next;
    logic [AW-1:0]          chk_idx_reg, chk_idx_next;
    logic                   pend_reg, pend_next;
    ctp_pkg::res_t          res_reg, res_next;

    logic [IW-1:0] id_ext;
    logic [IW-1:0] used_ext;
    logic          id_ok;
    logic [AW-1:0] id_addr;
    logic          found;
    logic          issue;
    logic          q_done;

    assign id_ext   = IW'(slot_id[3:0]);
    assign used_ext = IW'(used_reg);
    assign id_ok    = !slot_id[ctp_pkg::ID_W-1] && (id_ext < used_ext);
    assign id_addr  = AW'(slot_id[3:0]);

    // insert stops at the first inactive entry; tick walks all used entries
    assign found = (state_reg == ctp_pkg::ST_SCAN) && pend_reg &&
                   (func_reg == ctp_pkg::OP_INSERT) && !act_rdata;
    assign issue = (state_reg == ctp_pkg::ST_SCAN) && (rd_idx_reg < used_reg) && !found;
    assign q_done = !(act_rdata && (time_rdata != '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ctp_pkg::ST_IDLE;
            used_reg   <= '0;
            rd_idx_reg <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            rd_idx_reg <= rd_idx_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        dur_reg     <= dur_next;
        el_reg      <= el_next;
        chk_idx_reg <= chk_idx_next;
        res_reg     <= res_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        func_next    = func_reg;
        dur_next     = dur_reg;
        el_next      = el_reg;
        used_next    = used_reg;
        rd_idx_next  = rd_idx_reg;
        chk_idx_next = chk_idx_reg;
        pend_next    = pend_reg;
        res_next     = res_reg;
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        act_we       = 1'b0;
        act_wdata    = 1'b0;
        time_we      = 1'b0;
        time_wdata   = dur_reg;
        wr_addr      = chk_idx_reg;
        rd_addr      = rd_idx_reg[AW-1:0];

        case (state_reg)
            ctp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                rd_addr  = id_addr;
                if (in_valid)
                begin
                    func_next   = ctp_pkg::op_t'(func);
                    dur_next    = TIME_WIDTH'(duration);
                    el_next     = TIME_WIDTH'(elapsed);
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    res_next    = '0;
                    state_next  = ctp_pkg::ST_DONE;
                    case (ctp_pkg::op_t'(func))
                        ctp_pkg::OP_INSERT:
                        begin
                            if (id_ok)
                            begin
                                act_we            = 1'b1;
                                act_wdata         = 1'b1;
                                time_we           = 1'b1;
                                time_wdata        = TIME_WIDTH'(duration);
                                wr_addr           = id_addr;
                                res_next.slot_out = ctp_pkg::SLOT_W'(slot_id[3:0]);
                            end
                            else
                            begin
                                state_next = ctp_pkg::ST_SCAN;
                            end
                        end
                        ctp_pkg::OP_DELETE:
                        begin
                            if (id_ok)
                            begin
                                act_we  = 1'b1;
                                wr_addr = id_addr;
                            end
                        end
                        ctp_pkg::OP_CLEAR:
                        begin
                            used_next = '0;
                        end
                        ctp_pkg::OP_TICK:
                        begin
                            state_next = ctp_pkg::ST_SCAN;
                        end
                        ctp_pkg::OP_QUERY:
                        begin
                            if (id_ok)
                            begin
                                state_next = ctp_pkg::ST_QWAIT;
                            end
                            else
                            begin
                                res_next.done_res = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = ctp_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            ctp_pkg::ST_SCAN:
            begin
                // read of rd_idx overlaps the check of chk_idx, one entry behind
                pend_next = issue;
                if (issue)
                begin
                    rd_idx_next  = CW'(rd_idx_reg + 1'b1);
                    chk_idx_next = rd_idx_reg[AW-1:0];
                end
                if (pend_reg && (func_reg == ctp_pkg::OP_TICK) && act_rdata &&
                    (time_rdata != '0))
                begin
                    time_we    = 1'b1;
                    time_wdata = (time_rdata > el_reg) ? (time_rdata - el_reg) : '0;
                end
                if (found)
                begin
                    act_we            = 1'b1;
                    act_wdata         = 1'b1;
                    time_we           = 1'b1;
                    res_next.slot_out = ctp_pkg::SLOT_W'(chk_idx_reg);
                    state_next        = ctp_pkg::ST_DONE;
                end
                else if (!issue && !pend_reg)
                begin
                    state_next = ctp_pkg::ST_DONE;
                    if (func_reg == ctp_pkg::OP_INSERT)
                    begin
                        if (used_reg < CW'(NUM_SLOTS))
                        begin
                            act_we            = 1'b1;
                            act_wdata         = 1'b1;
                            time_we           = 1'b1;
                            wr_addr           = AW'(used_reg);
                            res_next.slot_out = ctp_pkg::SLOT_W'(used_reg);
                            used_next         = CW'(used_reg + 1'b1);
                        end
                        else
                        begin
                            res_next.full_res = 1'b1;
                        end
                    end
                end
            end

            ctp_pkg::ST_QWAIT:
            begin
                res_next.done_res  = q_done;
                res_next.remaining = q_done ? '0 : ctp_pkg::REM_W'(time_rdata);
                state_next         = ctp_pkg::ST_DONE;
            end

            ctp_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ctp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ctp_pkg::ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(NUM_SLOTS))
        else $error("slot count above bank size");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        issue && (act_we || time_we) |-> wr_addr != rd_addr)
        else $error("scan write hits the entry being read");

    a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> state_reg == ctp_pkg::ST_SCAN)
        else $error("pending read outside scan");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (func == ctp_pkg::OP_CLEAR) |=> used_reg == '0)
        else $error("delete-all left slots in use");

endmodule
